FILE: hw/rtl/bounded_hop_bfs_reach_counter_macros.svh
// Assertion macros used by the reach counter datapath.
`ifndef BOUNDED_HOP_BFS_REACH_COUNTER_MACROS_SVH
`define BOUNDED_HOP_BFS_REACH_COUNTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BHBFS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bhbfs: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define BHBFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bhbfs: next-cycle check failed");

`endif

FILE: hw/rtl/bhbfs_pkg.sv
// Shared constants and controller/datapath interface types for the reach counter.
package bhbfs_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int AW           = $clog2(MAX_VERTICES);
	localparam int ROW_W        = 64;
	localparam int VC_W         = 7;
	localparam int HOP_W        = 6;
	localparam int VID_W        = 6;
	localparam int CNT_W        = 6;
	localparam int PCT_W        = 7;
	localparam int PCT_SCALE    = 100;
	localparam int DIV_W        = 13;
	localparam int DIVI_W       = 4;

	localparam logic       OP_LOAD   = 1'b0;
	localparam logic       OP_QUERY  = 1'b1;
	localparam logic       REG_VCNT  = 1'b0;
	localparam logic       REG_HOPS  = 1'b1;

	localparam logic [VC_W-1:0]  VCNT_RESET = 7'd64;
	localparam logic [HOP_W-1:0] HOPS_RESET = 6'd6;

	typedef struct packed {
		logic load;
		logic query_start;
		logic scan_init;
		logic scan_issue;
		logic level_end;
		logic count_init;
		logic count_step;
		logic mul;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic hop_done;
		logic scan_last;
		logic next_zero;
		logic count_last;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage

FILE: hw/rtl/bhbfs_ctrl.sv
// Sequencing state machine for load, level scan, count and divide phases.
module bhbfs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             operation,
	output logic             in_stall,
	input  bhbfs_pkg::sts_t  sts,
	output bhbfs_pkg::cmd_t  cmd
);
	import bhbfs_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_DRAIN = 4'd3;
	localparam logic [3:0] S_LVL   = 4'd4;
	localparam logic [3:0] S_COUNT = 4'd5;
	localparam logic [3:0] S_MUL   = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (operation == OP_QUERY) begin
						cmd.query_start = 1'b1;
						state_d = S_CHK;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_CHK: begin
				if (sts.bad) begin
					state_d = S_FIN;
				end else if (sts.hop_done) begin
					cmd.count_init = 1'b1;
					state_d = S_COUNT;
				end else begin
					cmd.scan_init = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_LVL;
			S_LVL: begin
				if (sts.next_zero) begin
					cmd.count_init = 1'b1;
					state_d = S_COUNT;
				end else begin
					cmd.level_end = 1'b1;
					state_d = S_CHK;
				end
			end
			S_COUNT: begin
				cmd.count_step = 1'b1;
				if (sts.count_last) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

FILE: hw/rtl/bhbfs_dp.sv
// Datapath: adjacency memory, reached/frontier sets, counter, divider and output register.
module bhbfs_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bhbfs_pkg::cmd_t                     cmd,
	output bhbfs_pkg::sts_t                     sts,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [bhbfs_pkg::VC_W-1:0]          cfg_data,
	input  logic [bhbfs_pkg::VID_W-1:0]         row_index,
	input  logic [bhbfs_pkg::ROW_W-1:0]         row_bits,
	input  logic [bhbfs_pkg::VID_W-1:0]         start_vertex,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bhbfs_pkg::CNT_W-1:0]         reached_count,
	output logic [bhbfs_pkg::PCT_W-1:0]         reached_percent
);
	import bhbfs_pkg::*;
	`include "bounded_hop_bfs_reach_counter_macros.svh"

	logic [VC_W-1:0]   vertex_count_q;
	logic [HOP_W-1:0]  max_hops_q;

	logic [ROW_W-1:0]  adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_vld_q;
	logic [ROW_W-1:0]  rd_data_s1;
	logic              rd_en_s1;
	logic              rd_vld_s1;
	logic [VID_W-1:0]  rd_v_s1;

	logic [ROW_W-1:0]  reached_q;
	logic [ROW_W-1:0]  frontier_q;
	logic [ROW_W-1:0]  next_q;
	logic [ROW_W-1:0]  use_mask;
	logic [ROW_W-1:0]  next_new;
	logic [VC_W-1:0]   n_q;
	logic [VC_W-1:0]   n_eff;
	logic              bad_q;
	logic              start_bad;
	logic [VID_W-1:0]  v_q;
	logic [HOP_W-1:0]  hop_q;
	logic [VC_W-1:0]   cnt_q;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  count_res_q;
	logic [DIV_W-1:0]  dq_q;
	logic [VC_W:0]     rem_q;
	logic [VC_W:0]     trial;
	logic              trial_ge;
	logic [DIVI_W-1:0] div_i_q;
	logic              row_ok;
	logic              out_valid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCNT_RESET;
			max_hops_q     <= HOPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VCNT: vertex_count_q <= cfg_data;
				REG_HOPS: max_hops_q     <= cfg_data[HOP_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		if (vertex_count_q == '0) n_eff = VC_W'(1);
		else if (vertex_count_q > VC_W'(MAX_VERTICES)) n_eff = VC_W'(MAX_VERTICES);
		else n_eff = vertex_count_q;
	end

	assign start_bad = ({1'b0, start_vertex} >= n_eff);
	assign row_ok    = ({1'b0, row_index} < (VID_W+1)'(MAX_VERTICES));

	// adjacency memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.load && row_ok) adj_mem[row_index[AW-1:0]] <= row_bits;
		if (cmd.scan_issue) begin
			rd_data_s1 <= adj_mem[v_q[AW-1:0]];
			rd_v_s1    <= v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_en_s1  <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.load && row_ok) row_vld_q[row_index[AW-1:0]] <= 1'b1;
			rd_en_s1 <= cmd.scan_issue;
			if (cmd.scan_issue) rd_vld_s1 <= row_vld_q[v_q[AW-1:0]];
		end
	end

	always_comb begin
		for (int j = 0; j < ROW_W; j++) begin
			use_mask[j] = ((VC_W+1)'(j) < {1'b0, n_q});
		end
	end

	assign next_new = next_q & use_mask & ~reached_q;
	assign cnt_m1   = CNT_W'(cnt_q - VC_W'(1));
	assign trial    = {rem_q[VC_W-1:0], dq_q[DIV_W-1]};
	assign trial_ge = (trial >= {1'b0, n_q});

	// search sets and level bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q  <= '0;
			frontier_q <= '0;
		end else if (cmd.query_start) begin
			reached_q  <= start_bad ? '0 : (ROW_W'(1) << start_vertex);
			frontier_q <= start_bad ? '0 : (ROW_W'(1) << start_vertex);
		end else if (cmd.level_end) begin
			reached_q  <= reached_q | next_new;
			frontier_q <= next_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			n_q   <= n_eff;
			bad_q <= start_bad;
			hop_q <= '0;
		end
		if (cmd.level_end) hop_q <= hop_q + HOP_W'(1);
		if (cmd.scan_init) begin
			next_q <= '0;
			v_q    <= '0;
		end else if (cmd.scan_issue) begin
			v_q <= v_q + VID_W'(1);
		end else if (cmd.count_init) begin
			v_q   <= '0;
			cnt_q <= '0;
		end else if (cmd.count_step) begin
			v_q   <= v_q + VID_W'(1);
			cnt_q <= cnt_q + {{(VC_W-1){1'b0}}, reached_q[v_q]};
		end
		if (rd_en_s1 && rd_vld_s1 && frontier_q[rd_v_s1]) next_q <= next_q | rd_data_s1;
		if (cmd.mul) begin
			count_res_q <= cnt_m1;
			dq_q        <= DIV_W'({{(DIV_W-CNT_W){1'b0}}, cnt_m1} * DIV_W'(PCT_SCALE));
			rem_q       <= '0;
			div_i_q     <= '0;
		end else if (cmd.div_step) begin
			rem_q   <= trial_ge ? (trial - {1'b0, n_q}) : trial;
			dq_q    <= {dq_q[DIV_W-2:0], trial_ge};
			div_i_q <= div_i_q + DIVI_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			reached_count   <= bad_q ? '0 : count_res_q;
			reached_percent <= bad_q ? '0 : dq_q[PCT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;

	assign sts.bad        = bad_q;
	assign sts.hop_done   = (hop_q == max_hops_q);
	assign sts.scan_last  = ({1'b0, v_q} == (n_q - VC_W'(1)));
	assign sts.next_zero  = (next_new == '0);
	assign sts.count_last = ({1'b0, v_q} == (n_q - VC_W'(1)));
	assign sts.div_last   = (div_i_q == DIVI_W'(DIV_W-1));
	assign sts.out_busy   = out_valid_q && out_stall;

	`BHBFS_ASSERT_IMPL(a_frontier_in_reached, 1'b1, ((frontier_q & ~reached_q) == '0))
	`BHBFS_ASSERT_NEXT(a_frontier_stable_scan, cmd.scan_issue, $stable(frontier_q))
	`BHBFS_ASSERT_IMPL(a_out_slot_free, cmd.load_out, !(out_valid_q && out_stall))
	`BHBFS_ASSERT_IMPL(a_pct_range, cmd.load_out && !bad_q, (dq_q < DIV_W'(PCT_SCALE)))

endmodule

FILE: hw/rtl/bounded_hop_bfs_reach_counter.sv
// Top level of the bounded-hop breadth-first reach counter.
// A row load does not stall the input; loads may be sent back to back.
// A query ends when the hop limit is reached or a level adds no new vertex; each level reads
// every in-use row once. A start outside the vertex count skips the search and gives zero.
// A query's result waits while the previous result is still stalled at the output.
// Reset is asynchronous: all rows read as zero, sets clear, vertex_count 64, max_hops 6.
module bounded_hop_bfs_reach_counter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [bhbfs_pkg::VC_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic [bhbfs_pkg::VID_W-1:0]         row_index,
	input  logic [bhbfs_pkg::ROW_W-1:0]         row_bits,
	input  logic [bhbfs_pkg::VID_W-1:0]         start_vertex,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bhbfs_pkg::CNT_W-1:0]         reached_count,
	output logic [bhbfs_pkg::PCT_W-1:0]         reached_percent
);
	import bhbfs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bhbfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bhbfs_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.row_index       (row_index),
		.row_bits        (row_bits),
		.start_vertex    (start_vertex),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.reached_count   (reached_count),
		.reached_percent (reached_percent)
	);

endmodule
